@@ hdl/array_list_table_engine_defines.svh @@
// assertion helpers shared by the array list engine
`ifndef ARRAY_LIST_TABLE_ENGINE_DEFINES_SVH
`define ARRAY_LIST_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication
`define ALE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("array list engine check failed");

// next-cycle implication
`define ALE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("array list engine check failed");

`endif

@@ hdl/ale_pkg.sv @@
package ale_pkg;

  // operation codes
  localparam logic [3:0] FN_APPEND          = 4'd0;
  localparam logic [3:0] FN_GET             = 4'd1;
  localparam logic [3:0] FN_PUT             = 4'd2;
  localparam logic [3:0] FN_SWAP            = 4'd3;
  localparam logic [3:0] FN_REMOVE_AT       = 4'd4;
  localparam logic [3:0] FN_INSERT_AT       = 4'd5;
  localparam logic [3:0] FN_POP             = 4'd6;
  localparam logic [3:0] FN_TOP             = 4'd7;
  localparam logic [3:0] FN_CONTAINS        = 4'd8;
  localparam logic [3:0] FN_REMOVE_VALUE    = 4'd9;
  localparam logic [3:0] FN_SORTED_INSERT   = 4'd10;
  localparam logic [3:0] FN_SORTED_CONTAINS = 4'd11;
  localparam logic [3:0] FN_SORTED_REMOVE   = 4'd12;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_RD_WAIT,
    S_SWAP_A,
    S_SWAP_B,
    S_SWAP_W,
    S_SHD_RD,
    S_SHD_WR,
    S_SHU_RD,
    S_SHU_WR,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_BS_RD,
    S_BS_CMP,
    S_CHK_CMP
  } state_t;

endpackage

@@ hdl/array_list_table_engine.sv @@
// channel    | handshake        | fields
// -----------+------------------+-------------------------------------------
// request    | start / busy     | func, position, second_position, item_value
// result     | done (one cycle) | read_value, found, status, count
//
// a request is taken when start is high and busy is low; append, put and pop
// finish in the decide state, get and top after one store read, swap after
// two reads and two writes, and shifts, scans and the sorted operations walk
// the store with one memory read or write per step
// busy falls in the cycle done is shown, so a new start can meet that cycle
// rst (synchronous) empties the list; store contents stay as they were
// the receiver cannot stall: done lasts exactly one cycle
module array_list_table_engine #(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  func,
  input  logic [7:0]  position,
  input  logic [7:0]  second_position,
  input  logic signed [31:0] item_value,
  output logic        done,
  output logic signed [31:0] read_value,
  output logic        found,
  output logic [1:0]  status,
  output logic [8:0]  count
);
  import ale_pkg::*;
`include "array_list_table_engine_defines.svh"

  localparam int AW = $clog2(CAPACITY);       // store address width
  localparam int CW = $clog2(CAPACITY + 1);   // fill count width
  localparam int PW = (CW > 8) ? CW : 8;      // width for index bound checks

  state_t state, state_next;

  // latched request
  logic [3:0]  fn, fn_next;
  logic [7:0]  pos, pos_next;
  logic [7:0]  pos2, pos2_next;
  logic [31:0] val, val_next;

  // list state and walk registers
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] k, k_next;        // walk / shift index
  logic [CW-1:0] lo, lo_next;      // search low bound, also insert target
  logic [CW-1:0] hi, hi_next;      // search high bound
  logic [31:0]   tmp, tmp_next;    // first swap operand

  // result staging
  logic        done_next;
  logic [31:0] rv_next;
  logic        found_next;
  logic [1:0]  status_next;

  // memory port
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  logic [CW-1:0] kp1, km1, mid;
  logic [PW-1:0] pos_x, pos2_x, cnt_x;
  logic          is_full, is_empty, is_remove;

  ale_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign kp1      = k + 1'b1;
  assign km1      = k - 1'b1;
  assign mid      = lo + ((hi - lo) >> 1);
  assign pos_x    = PW'(pos);
  assign pos2_x   = PW'(pos2);
  assign cnt_x    = PW'(cnt);
  assign is_full  = (cnt == CW'(CAPACITY));
  assign is_empty = (cnt == '0);
  // operations that end in a shift-down and report the removal
  assign is_remove = (fn == FN_REMOVE_VALUE) || (fn == FN_SORTED_REMOVE);

  assign busy  = (state != S_IDLE);
  assign count = 9'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    fn   <= fn_next;
    pos  <= pos_next;
    pos2 <= pos2_next;
    val  <= val_next;
    k    <= k_next;
    lo   <= lo_next;
    hi   <= hi_next;
    tmp  <= tmp_next;
    if (done_next) begin
      read_value <= rv_next;
      found      <= found_next;
      status     <= status_next;
    end
  end

  always_comb begin
    state_next  = state;
    fn_next     = fn;
    pos_next    = pos;
    pos2_next   = pos2;
    val_next    = val;
    cnt_next    = cnt;
    k_next      = k;
    lo_next     = lo;
    hi_next     = hi;
    tmp_next    = tmp;
    done_next   = 1'b0;
    rv_next     = '0;
    found_next  = 1'b0;
    status_next = ST_OK;
    we          = 1'b0;
    waddr       = k[AW-1:0];
    wdata       = rdata;
    raddr       = k[AW-1:0];

    case (state)
      S_IDLE: begin
        if (start) begin
          fn_next    = func;
          pos_next   = position;
          pos2_next  = second_position;
          val_next   = item_value;
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        case (fn)
          FN_APPEND: begin
            if (is_full) begin
              status_next = ST_FULL;
            end else begin
              we       = 1'b1;
              waddr    = cnt[AW-1:0];
              wdata    = val;
              cnt_next = cnt + 1'b1;
            end
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
          FN_GET: begin
            if (pos_x < cnt_x) begin
              raddr      = AW'(pos);
              state_next = S_RD_WAIT;
            end else begin
              status_next = ST_RANGE;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end
          end
          FN_PUT: begin
            if (pos_x < cnt_x) begin
              we    = 1'b1;
              waddr = AW'(pos);
              wdata = val;
            end else begin
              status_next = ST_RANGE;
            end
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
          FN_SWAP: begin
            if (pos_x < cnt_x && pos2_x < cnt_x) begin
              raddr      = AW'(pos);
              state_next = S_SWAP_A;
            end else begin
              status_next = ST_RANGE;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end
          end
          FN_REMOVE_AT: begin
            if (pos_x < cnt_x) begin
              k_next     = CW'(pos);
              state_next = S_SHD_RD;
            end else begin
              status_next = ST_RANGE;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end
          end
          FN_INSERT_AT: begin
            if (is_full) begin
              status_next = ST_FULL;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else if (pos_x > cnt_x) begin
              status_next = ST_RANGE;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else begin
              lo_next    = CW'(pos);
              k_next     = cnt;
              state_next = S_SHU_RD;
            end
          end
          FN_POP: begin
            if (is_empty) begin
              status_next = ST_EMPTY;
            end else begin
              cnt_next = cnt - 1'b1;
            end
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
          FN_TOP: begin
            if (is_empty) begin
              status_next = ST_EMPTY;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else begin
              raddr      = AW'(cnt - 1'b1);
              state_next = S_RD_WAIT;
            end
          end
          FN_CONTAINS, FN_REMOVE_VALUE: begin
            if (is_empty) begin
              status_next = ST_EMPTY;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else begin
              k_next     = '0;
              state_next = S_SCAN_RD;
            end
          end
          FN_SORTED_INSERT: begin
            if (is_full) begin
              status_next = ST_FULL;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else begin
              lo_next    = '0;
              hi_next    = cnt;
              state_next = S_BS_RD;
            end
          end
          FN_SORTED_CONTAINS, FN_SORTED_REMOVE: begin
            lo_next    = '0;
            hi_next    = cnt;
            state_next = S_BS_RD;
          end
          default: begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end

      S_RD_WAIT: begin
        rv_next    = rdata;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      S_SWAP_A: begin
        tmp_next   = rdata;
        raddr      = AW'(pos2);
        state_next = S_SWAP_B;
      end

      S_SWAP_B: begin
        we         = 1'b1;
        waddr      = AW'(pos);
        wdata      = rdata;
        state_next = S_SWAP_W;
      end

      S_SWAP_W: begin
        we         = 1'b1;
        waddr      = AW'(pos2);
        wdata      = tmp;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      // shift down: entry k takes entry k+1 until the tail
      S_SHD_RD: begin
        if (kp1 < cnt) begin
          raddr      = kp1[AW-1:0];
          state_next = S_SHD_WR;
        end else begin
          cnt_next   = cnt - 1'b1;
          found_next = is_remove;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_SHD_WR: begin
        we         = 1'b1;
        waddr      = k[AW-1:0];
        wdata      = rdata;
        k_next     = kp1;
        state_next = S_SHD_RD;
      end

      // shift up: entry k takes entry k-1 down to the insert point
      S_SHU_RD: begin
        if (k > lo) begin
          raddr      = km1[AW-1:0];
          state_next = S_SHU_WR;
        end else begin
          we         = 1'b1;
          waddr      = lo[AW-1:0];
          wdata      = val;
          cnt_next   = cnt + 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_SHU_WR: begin
        we         = 1'b1;
        waddr      = k[AW-1:0];
        wdata      = rdata;
        k_next     = km1;
        state_next = S_SHU_RD;
      end

      S_SCAN_RD: begin
        raddr      = k[AW-1:0];
        state_next = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (rdata == val) begin
          if (fn == FN_REMOVE_VALUE) begin
            state_next = S_SHD_RD;
          end else begin
            found_next = 1'b1;
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        end else if (kp1 < cnt) begin
          k_next     = kp1;
          state_next = S_SCAN_RD;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      // lower-bound binary search
      S_BS_RD: begin
        if (lo < hi) begin
          raddr      = mid[AW-1:0];
          k_next     = mid;
          state_next = S_BS_CMP;
        end else if (fn == FN_SORTED_INSERT) begin
          k_next     = cnt;
          state_next = S_SHU_RD;
        end else if (lo < cnt) begin
          raddr      = lo[AW-1:0];
          state_next = S_CHK_CMP;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_BS_CMP: begin
        if ($signed(rdata) < $signed(val)) begin
          lo_next = kp1;
        end else begin
          hi_next = k;
        end
        state_next = S_BS_RD;
      end

      S_CHK_CMP: begin
        if (rdata == val && fn == FN_SORTED_REMOVE) begin
          k_next     = lo;
          state_next = S_SHD_RD;
        end else begin
          found_next = (rdata == val);
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result cycle always leaves the engine ready
  `ALE_ASSERT_IMP(a_done_ready, clk, rst, done, !busy)
  // a taken request makes the engine busy in the next cycle, with no result yet
  `ALE_ASSERT_NXT(a_start_busy, clk, rst, start && !busy, busy && !done)
  // results are single-cycle pulses
  `ALE_ASSERT_NXT(a_done_pulse, clk, rst, done, !done)
  // fill count never passes the capacity
  `ALE_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, cnt <= CW'(CAPACITY))
  // a full status is only reported on a full list
  `ALE_ASSERT_IMP(a_full_status, clk, rst, done && status == ST_FULL, is_full)

endmodule

@@ hdl/ale_ram.sv @@
module ale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sim/tb_array_list_table_engine.sv @@
`timescale 1ns / 1ps

module tb_array_list_table_engine;
  import ale_pkg::*;

  localparam int CAP = 256;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_CYCLES = 2 * CAP + 20;

  typedef struct {
    logic [3:0]         op;
    logic [7:0]         pos_a;
    logic [7:0]         pos_b;
    logic signed [31:0] val;
  } list_req_t;

  typedef struct {
    logic signed [31:0] rd;
    logic               hit;
    logic [1:0]         st;
    logic [8:0]         cnt;
  } list_resp_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [3:0] func;
  logic [7:0] position;
  logic [7:0] second_position;
  logic signed [31:0] item_value;
  logic done;
  logic signed [31:0] read_value;
  logic found;
  logic [1:0] status;
  logic [8:0] count;

  array_list_table_engine #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .position(position), .second_position(second_position),
    .item_value(item_value), .done(done), .read_value(read_value),
    .found(found), .status(status), .count(count)
  );

  // mirror of the list contents and its length
  logic signed [31:0] shadow_list [CAP];
  int unsigned shadow_len = 0;

  list_req_t  pending_reqs[$];
  list_resp_t expected_resps[$];

  int errors = 0;
  int accepted_reqs = 0;
  int checked_resps = 0;
  int idle_cycles = 0;
  int op_hits [16] = '{default: 0};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // remove the entry at idx, closing the gap
  function automatic void shadow_delete(int unsigned idx);
    for (int unsigned k = idx; k + 1 < shadow_len; k++) shadow_list[k] = shadow_list[k + 1];
    shadow_len--;
  endfunction

  // open a gap at idx and store v there
  function automatic void shadow_insert(int unsigned idx, logic signed [31:0] v);
    for (int unsigned k = shadow_len; k > idx; k--) shadow_list[k] = shadow_list[k - 1];
    shadow_list[idx] = v;
    shadow_len++;
  endfunction

  // first index whose entry is not below v (signed order)
  function automatic int unsigned lower_bound_of(logic signed [31:0] v);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = shadow_len;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (shadow_list[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // apply one request to the mirror and return what the block should answer
  function automatic list_resp_t apply_request(list_req_t r);
    list_resp_t o;
    logic signed [31:0] t;
    int unsigned k;
    o.rd = '0;
    o.hit = 1'b0;
    o.st = ST_OK;
    case (r.op)
      FN_APPEND: begin
        if (shadow_len >= CAP) o.st = ST_FULL;
        else begin
          shadow_list[shadow_len] = r.val;
          shadow_len++;
        end
      end
      FN_GET: begin
        if (r.pos_a < shadow_len) o.rd = shadow_list[r.pos_a];
        else o.st = ST_RANGE;
      end
      FN_PUT: begin
        if (r.pos_a < shadow_len) shadow_list[r.pos_a] = r.val;
        else o.st = ST_RANGE;
      end
      FN_SWAP: begin
        if (r.pos_a < shadow_len && r.pos_b < shadow_len) begin
          t = shadow_list[r.pos_a];
          shadow_list[r.pos_a] = shadow_list[r.pos_b];
          shadow_list[r.pos_b] = t;
        end else o.st = ST_RANGE;
      end
      FN_REMOVE_AT: begin
        if (r.pos_a < shadow_len) shadow_delete(r.pos_a);
        else o.st = ST_RANGE;
      end
      FN_INSERT_AT: begin
        if (shadow_len >= CAP) o.st = ST_FULL;
        else if (r.pos_a > shadow_len) o.st = ST_RANGE;
        else shadow_insert(r.pos_a, r.val);
      end
      FN_POP: begin
        if (shadow_len == 0) o.st = ST_EMPTY;
        else shadow_len--;
      end
      FN_TOP: begin
        if (shadow_len == 0) o.st = ST_EMPTY;
        else o.rd = shadow_list[shadow_len - 1];
      end
      FN_CONTAINS, FN_REMOVE_VALUE: begin
        if (shadow_len == 0) o.st = ST_EMPTY;
        else begin
          for (k = 0; k < shadow_len; k++) begin
            if (shadow_list[k] == r.val) break;
          end
          if (k < shadow_len) begin
            o.hit = 1'b1;
            if (r.op == FN_REMOVE_VALUE) shadow_delete(k);
          end
        end
      end
      FN_SORTED_INSERT: begin
        if (shadow_len >= CAP) o.st = ST_FULL;
        else shadow_insert(lower_bound_of(r.val), r.val);
      end
      FN_SORTED_CONTAINS, FN_SORTED_REMOVE: begin
        k = lower_bound_of(r.val);
        if (k < shadow_len && shadow_list[k] == r.val) begin
          o.hit = 1'b1;
          if (r.op == FN_SORTED_REMOVE) shadow_delete(k);
        end
      end
      default: ;
    endcase
    o.cnt = shadow_len[8:0];
    return o;
  endfunction

  // stimulus generation tracks its own length so positions can aim at the edges
  int unsigned plan_len;
  bit plan_sorted;

  function automatic void queue_req(logic [3:0] op, logic [7:0] a, logic [7:0] b,
                                    logic signed [31:0] v);
    list_req_t r;
    r.op = op;
    r.pos_a = a;
    r.pos_b = b;
    r.val = v;
    pending_reqs.push_back(r);
  endfunction

  // values biased to a narrow range so searches hit, with extremes mixed in
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  // index around the current length: mostly legal, sometimes just past or anywhere in the byte range
  function automatic logic [7:0] pick_index(int unsigned len);
    int unsigned p;
    case ($urandom_range(0, 7))
      0: p = $urandom_range(0, 255);
      1: p = len;
      2: p = (len > 0) ? len - 1 : 0;
      default: p = (len > 0) ? $urandom_range(0, len - 1) : 0;
    endcase
    return p[7:0];
  endfunction

  // sampled at the rising edge: was the request held last cycle taken
  logic busy_at_edge;
  logic taken_at_edge;

  // driver: bursts of back-to-back requests separated by random gaps
  int gap_left;
  int burst_left;
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      func <= FN_APPEND;
      position <= '0;
      second_position <= '0;
      item_value <= '0;
      gap_left <= 0;
      burst_left <= 0;
    end else if (!(start && !busy_at_edge) && start) begin
      // request still waiting for the block; hold it
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_reqs.size() > 0) begin
      func <= pending_reqs[0].op;
      position <= pending_reqs[0].pos_a;
      second_position <= pending_reqs[0].pos_b;
      item_value <= pending_reqs[0].val;
      start <= 1'b1;
      void'(pending_reqs.pop_front());
      if (burst_left > 0) burst_left <= burst_left - 1;
      else begin
        burst_left <= $urandom_range(0, 12);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: take requests, predict, compare results
  always @(posedge clk) begin
    list_req_t r;
    list_resp_t e;
    busy_at_edge = busy;
    taken_at_edge = 1'b0;
    if (!rst) begin
      if (done) begin
        if (expected_resps.size() == 0) begin
          $display("%0t result with nothing outstanding: rd=%0d found=%0b st=%0d cnt=%0d",
                   $time, read_value, found, status, count);
          errors++;
        end else begin
          e = expected_resps.pop_front();
          checked_resps++;
          if (read_value !== e.rd) begin
            $display("%0t read_value expected %0d actual %0d", $time, e.rd, read_value);
            errors++;
          end
          if (found !== e.hit) begin
            $display("%0t found expected %0b actual %0b", $time, e.hit, found);
            errors++;
          end
          if (status !== e.st) begin
            $display("%0t status expected %0d actual %0d", $time, e.st, status);
            errors++;
          end
          if (count !== e.cnt) begin
            $display("%0t count expected %0d actual %0d", $time, e.cnt, count);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        r.op = func;
        r.pos_a = position;
        r.pos_b = second_position;
        r.val = item_value;
        expected_resps.push_back(apply_request(r));
        accepted_reqs++;
        op_hits[func]++;
        taken_at_edge = 1'b1;
      end
      if (done || taken_at_edge) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("array_list_table_engine verification failed");
        $finish;
      end
    end
  end

  // random phase: mostly sorted ops on a sorted list, or mixed ops when plan_sorted is clear
  task automatic plan_random(int n);
    int kind;
    logic [3:0] op;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      // steer the length: shrink when near full
      if (plan_sorted) begin
        if (kind < 40) op = FN_SORTED_INSERT;
        else if (kind < 60) op = FN_SORTED_CONTAINS;
        else if (kind < 75) op = FN_SORTED_REMOVE;
        else if (kind < 85) op = FN_GET;
        else op = FN_TOP;
      end else begin
        op = 4'($urandom_range(0, 15));
        if (kind < 15) op = FN_APPEND;
        else if (kind < 22) op = FN_INSERT_AT;
      end
      if (plan_len > 200 && $urandom_range(0, 1)) op = FN_POP;
      queue_req(op, pick_index(plan_len), pick_index(plan_len), pick_value());
      // rough length tracking, the exact value comes from the mirror
      if (op == FN_APPEND || op == FN_INSERT_AT || op == FN_SORTED_INSERT) begin
        if (plan_len < CAP) plan_len++;
      end else if ((op == FN_POP || op == FN_REMOVE_AT) && plan_len > 0) plan_len--;
    end
  endtask

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty-list cases first, nothing stored yet
    queue_req(FN_POP, 0, 0, 0);
    queue_req(FN_TOP, 0, 0, 0);
    queue_req(FN_CONTAINS, 0, 0, 5);
    queue_req(FN_REMOVE_VALUE, 0, 0, 5);
    queue_req(FN_SORTED_CONTAINS, 0, 0, 5);
    queue_req(FN_SORTED_REMOVE, 0, 0, 5);
    queue_req(FN_GET, 0, 0, 0);
    queue_req(FN_PUT, 0, 0, 1);
    queue_req(FN_SWAP, 0, 0, 0);
    queue_req(FN_REMOVE_AT, 0, 0, 0);
    queue_req(FN_INSERT_AT, 1, 0, 1);
    queue_req(4'd13, 8'hff, 8'hff, 32'shffffffff);
    // extremes of value and index
    queue_req(FN_SORTED_INSERT, 0, 0, 32'sh7fffffff);
    queue_req(FN_SORTED_INSERT, 0, 0, 32'sh80000000);
    queue_req(FN_SORTED_INSERT, 0, 0, 0);
    queue_req(FN_SORTED_CONTAINS, 0, 0, 32'sh80000000);
    queue_req(FN_SORTED_CONTAINS, 0, 0, 1);
    queue_req(FN_INSERT_AT, 3, 0, 32'sh55555555);
    queue_req(FN_GET, 3, 0, 0);
    queue_req(FN_SWAP, 0, 3, 0);
    queue_req(FN_SWAP, 0, 4, 0);
    queue_req(FN_GET, 8'hff, 0, 0);
    queue_req(FN_REMOVE_VALUE, 0, 0, 32'sh7fffffff);
    queue_req(4'd15, 8'haa, 8'h55, 32'shaaaaaaaa);
    // fill to capacity to hit the full status
    for (int i = 0; i < CAP; i++) queue_req(FN_APPEND, 8'hff, 8'h00, $urandom);
    queue_req(FN_APPEND, 0, 0, 1);
    queue_req(FN_INSERT_AT, 0, 0, 1);
    queue_req(FN_SORTED_INSERT, 0, 0, 1);
    queue_req(FN_GET, 8'hff, 8'hff, 0);
    queue_req(FN_PUT, 8'hff, 0, 32'sh12345678);
    queue_req(FN_REMOVE_AT, 0, 0, 0);
    queue_req(FN_INSERT_AT, 0, 0, 32'shdeadbeef);
    // drain back to empty
    for (int i = 0; i < CAP; i++) queue_req(FN_POP, 0, 0, 0);
    plan_len = 0;

    // random: sorted section, unsorted section, sorted section again
    plan_sorted = 1;
    plan_random(250);
    for (int i = 0; i < plan_len + 8; i++) queue_req(FN_POP, 0, 0, 0);
    plan_len = 0;
    plan_sorted = 0;
    plan_random(250);
    for (int i = 0; i < plan_len + 8; i++) queue_req(FN_POP, 0, 0, 0);
    plan_len = 0;
    plan_sorted = 1;
    plan_random(250);

    wait (pending_reqs.size() == 0 && !start);
    wait (expected_resps.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d results over all thirteen list operations",
             accepted_reqs, checked_resps);
    $display("sorted insert/contains/remove %0d/%0d/%0d, full and empty edges included",
             op_hits[FN_SORTED_INSERT], op_hits[FN_SORTED_CONTAINS],
             op_hits[FN_SORTED_REMOVE]);
    if (errors == 0 && expected_resps.size() == 0) begin
      $display("array_list_table_engine verification clean");
    end else begin
      $display("array_list_table_engine verification failed");
    end
    $finish;
  end

endmodule
